// ----- sv/rau_pkg.sv -----
// Shared types, constants and helpers for the rational arithmetic unit.
package rau_pkg;
    localparam int WIDTH = 32;
    localparam int DW = 2 * WIDTH;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_FORM,
        S_GCD,
        S_QN,
        S_QD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [DW-1:0] quo;
        logic [DW-1:0] rem;
    } t_div_rsp;

    function automatic logic [DW-1:0] f_mag(input logic [DW-1:0] v);
        f_mag = v[DW-1] ? (~v + 1'b1) : v;
    endfunction
endpackage

// ----- sv/rau_if.sv -----
// Valid/ready stream interfaces for operands and results.
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        less;
    logic        equal;
    logic        overflow;
    modport source (output valid, res_num, res_den, less, equal, overflow, input ready);
    modport sink   (input valid, res_num, res_den, less, equal, overflow, output ready);
endinterface

// ----- sv/rau_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rau_pkg::t_div_req  i_req,
    output rau_pkg::t_div_rsp  o_rsp
);
    import rau_pkg::*;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_d;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;

    assign w_sh  = {r_r, r_q[DW-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                // shift in next dividend bit, subtract if it fits
                r_q <= {r_q[DW-2:0], ~w_sub[DW]};
                r_r <= w_sub[DW] ? w_sh[DW-1:0] : w_sub[DW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_r;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("busy with zero count");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("start while busy");
endmodule

// ----- sv/rau_ctrl.sv -----
// Sequencer: products, Euclid loop and final quotients over the shared divider.
module rau_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rau_in_if.sink             in_ch,
    rau_out_if.source          out_ch,
    output rau_pkg::t_div_req  o_req,
    input  rau_pkg::t_div_rsp  i_rsp
);
    import rau_pkg::*;

    t_state r_state, n_state;
    logic [2:0]        r_op;
    logic signed [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [DW-1:0] r_p0, r_p1;
    logic signed [DW-1:0] r_n, r_d, r_x, r_y;
    logic [31:0] r_rn, r_rd;
    logic r_less, r_eq, r_ovf, r_ov, r_n0;

    logic signed [WIDTH-1:0] w_ma, w_mb;
    logic signed [DW-1:0] w_prod, w_qs, w_rs;
    logic signed [WIDTH-1:0] w_nn, w_nd;
    logic signed [DW-1:0] w_fn, w_fd;

    // multiplier shared by the two product states; operand select by state
    always_comb begin
        w_ma = r_an;
        w_mb = r_bd;
        unique case (r_state)
            S_MUL1: begin
                w_ma = r_an;
                w_mb = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            S_MUL2: begin
                w_ma = r_ad;
                w_mb = (r_op == OP_MUL || r_op == OP_ADD || r_op == OP_SUB) ?
                       ((r_op == OP_MUL) ? r_bd : r_bn) : r_bn;
            end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // numerator and denominator to be reduced
    assign w_fn = (r_op == OP_ADD) ? r_p0 + r_p1 :
                  (r_op == OP_SUB) ? r_p0 - r_p1 : r_p0;
    assign w_fd = (r_op == OP_DIV) ? r_p1 : r_ad * r_bd;

    // sign fixups for the divider's unsigned answers
    assign w_rs = r_x[DW-1] ? -$signed(i_rsp.rem) : $signed(i_rsp.rem);
    assign w_qs = (r_x[DW-1] ^ r_y[DW-1]) ? -$signed(i_rsp.quo) : $signed(i_rsp.quo);
    assign w_nn = w_qs[WIDTH-1:0];
    assign w_nd = r_n0 ? r_ad : w_qs[WIDTH-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_ch.valid) n_state = S_MUL1;
            S_MUL1: n_state = (r_op > 3'(OP_CMP)) ? S_DONE : S_MUL2;
            S_MUL2: n_state = S_FORM;
            S_FORM: begin
                if (r_op == OP_CMP || (r_op == OP_DIV && r_bn == '0)) n_state = S_DONE;
                else n_state = S_GCD;
            end
            S_GCD: begin
                if (r_y == '0) n_state = (r_x == '0) ? S_DONE : S_QN;
            end
            S_QN: if (i_rsp.done) n_state = S_QD;
            S_QD: if (i_rsp.done) n_state = S_DONE;
            S_DONE: if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // divider start requests; operands forwarded from the values being loaded
    always_comb begin
        o_req.start    = 1'b0;
        o_req.dividend = f_mag(r_x);
        o_req.divisor  = f_mag(r_y);
        unique case (r_state)
            S_FORM: begin
                o_req.dividend = f_mag(w_fn);
                o_req.divisor  = f_mag(w_fd);
                o_req.start    = (n_state == S_GCD) && (w_fd != '0);
            end
            S_GCD: begin
                o_req.dividend = f_mag(r_y);
                o_req.divisor  = f_mag(w_rs);
                o_req.start    = i_rsp.done && (w_rs != '0);
            end
            S_QN: begin
                o_req.dividend = f_mag(r_d);
                o_req.start    = i_rsp.done;
            end
            default: ;
        endcase
        if (r_state == S_GCD && r_y == '0 && r_x != '0) begin
            o_req.start    = 1'b1;
            o_req.dividend = f_mag(r_n);
            o_req.divisor  = f_mag(r_x);
        end
    end

    assign in_ch.ready    = (r_state == S_IDLE);
    assign out_ch.valid   = (r_state == S_DONE);
    assign out_ch.res_num = r_rn;
    assign out_ch.res_den = r_rd;
    assign out_ch.less    = r_less;
    assign out_ch.equal   = r_eq;
    assign out_ch.overflow = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_n0 <= 1'b0;
        unique case (r_state)
            S_IDLE: if (in_ch.valid) begin
                r_op <= in_ch.op;
                r_an <= in_ch.a_num[WIDTH-1:0];
                r_ad <= in_ch.a_den[WIDTH-1:0];
                r_bn <= in_ch.b_num[WIDTH-1:0];
                r_bd <= in_ch.b_den[WIDTH-1:0];
                r_rn <= '0; r_rd <= '0;
                r_less <= 1'b0; r_eq <= 1'b0; r_ovf <= 1'b0; r_ov <= 1'b0;
            end
            S_MUL1: r_p0 <= w_prod;
            S_MUL2: r_p1 <= (r_op == OP_DIV) ? (w_prod) : w_prod;
            S_FORM: begin
                // operands for Euclid: n and d
                if (r_op == OP_CMP) begin
                    r_less <= r_p0 < r_p1;
                    r_eq   <= r_p0 == r_p1;
                end else if (r_op == OP_DIV && r_bn == '0) begin
                    r_rn <= 32'(r_an);
                    r_rd <= 32'(r_ad);
                end else begin
                    r_n <= w_fn;
                    r_x <= w_fn;
                    r_d <= w_fd;
                    r_y <= w_fd;
                end
            end
            S_GCD: begin
                if (r_y == '0) begin
                    if (r_x == '0) begin
                        r_rn <= 32'(r_n[WIDTH-1:0]);
                        r_rd <= 32'(r_d[WIDTH-1:0]);
                        r_ovf <= 1'b0;
                    end else begin
                        r_y <= r_x; // y now holds the gcd
                        r_x <= r_n;
                    end
                end else if (i_rsp.done) begin
                    r_x <= r_y;
                    r_y <= w_rs;
                end
            end
            S_QN: if (i_rsp.done) begin
                r_rn <= {{(32-WIDTH){w_nn[WIDTH-1]}}, w_nn};
                r_ov <= w_qs != DW'(w_nn);
                r_x  <= r_d;
            end
            S_QD: if (i_rsp.done) begin
                r_rd  <= {{(32-WIDTH){w_qs[WIDTH-1]}}, w_qs[WIDTH-1:0]};
                r_ovf <= r_ov || (w_qs != DW'(w_nd));
            end
            default: ;
        endcase
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !(out_ch.less && out_ch.equal)) else $error("less and equal");
endmodule

// ----- sv/rational_arithmetic_unit_core.sv -----
// Top level of the rational arithmetic unit with gcd reduction.
//  channel | dir | payload
//  in_ch   | in  | op, a_num, a_den, b_num, b_den
//  out_ch  | out | res_num, res_den, less, equal, overflow
// One item at a time: for compare the result passes through the multiply and
// form states to done; arithmetic adds a divider pass per Euclid remainder
// step and two more for the final quotients, all on the single bit-serial
// 64-bit divider.
// Reset (synchronous, active low) returns the sequencer to idle.
// A result holds on out_ch until taken; in_ch is not ready until then.
module rational_arithmetic_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);
    import rau_pkg::*;

    t_div_req w_req;
    t_div_rsp w_rsp;

    // sequencer owns the channels; divider is the shared unit
    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .o_req   (w_req),
        .i_rsp   (w_rsp)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );
endmodule
